@@ src/qsm_pkg.sv @@
// Shared widths and index constants for the quaternion/scale to matrix core.
// No dependencies; imported by quaternion_scale_to_matrix_core.
package qsm_pkg;

  // Port widths
  localparam int QUAT_W  = 16;  // Q1.14
  localparam int SCALE_W = 16;  // Q8.8
  localparam int POS_W   = 32;  // Q16.16
  localparam int OUT_W   = 24;  // Q9.14, saturated

  // Fixed-point layout
  localparam int Q_FRAC  = 14;
  localparam int S_FRAC  = 8;

  // Internal widths
  localparam int MUL1_W  = 2 * QUAT_W;              // raw pair product, Q3.28
  localparam int PAIR_W  = MUL1_W - Q_FRAC;         // pair product after >>> 14
  localparam int TERM_W  = PAIR_W + 2;              // 2*(a +/- b)
  localparam int MUL2_W  = TERM_W + SCALE_W;        // term * scale, Q.22
  localparam int SHR_W   = MUL2_W - S_FRAC;         // after >>> 8

  // One in Q.14
  localparam logic signed [TERM_W-1:0] ONE_Q14 = TERM_W'(1) <<< Q_FRAC;

  // Saturation bounds
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Pipeline depth from transfer to result strobe
  localparam int LATENCY = 4;

  // Pair product slots
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_XZ = 4;
  localparam int P_YZ = 5;
  localparam int P_WX = 6;
  localparam int P_WY = 7;
  localparam int P_WZ = 8;
  localparam int N_PAIR = 9;

  // Matrix entries, row-major
  localparam int N_DIM = 3;
  localparam int N_ENT = N_DIM * N_DIM;

  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [MUL2_W-1:0] mul2_t;
  typedef logic signed [OUT_W-1:0]  ent_t;

  // Clamp a shifted Q.14 value to the output range
  function automatic ent_t sat_out(input logic signed [SHR_W-1:0] v);
    logic hi_ok;
    logic lo_ok;
    hi_ok = (v <= SHR_W'(OUT_MAX));
    lo_ok = (v >= SHR_W'(OUT_MIN));
    if (!hi_ok) begin
      sat_out = OUT_MAX;
    end else if (!lo_ok) begin
      sat_out = OUT_MIN;
    end else begin
      sat_out = v[OUT_W-1:0];
    end
  endfunction

endpackage

@@ src/quaternion_scale_to_matrix_core.sv @@
// Quaternion and per-axis scale to scaled 3x3 rotation matrix, position pass-through.
// Depends on qsm_pkg for widths, slot indexes and the saturation function.
// Throughput: one transfer per cycle; busy is low except while rst is high.
// Four stages: pair products, terms, scale products, shift and clamp.
// Reset (synchronous, rst high) clears the stage valid bits; results in flight are dropped.
module quaternion_scale_to_matrix_core
  import qsm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [QUAT_W-1:0]   quat_x,
  input  logic signed [QUAT_W-1:0]   quat_y,
  input  logic signed [QUAT_W-1:0]   quat_z,
  input  logic signed [QUAT_W-1:0]   quat_w,
  input  logic signed [SCALE_W-1:0]  scale_x,
  input  logic signed [SCALE_W-1:0]  scale_y,
  input  logic signed [SCALE_W-1:0]  scale_z,
  input  logic signed [POS_W-1:0]    pos_x,
  input  logic signed [POS_W-1:0]    pos_y,
  input  logic signed [POS_W-1:0]    pos_z,
  output logic                       done,
  output logic signed [OUT_W-1:0]    rs_00,
  output logic signed [OUT_W-1:0]    rs_01,
  output logic signed [OUT_W-1:0]    rs_02,
  output logic signed [OUT_W-1:0]    rs_10,
  output logic signed [OUT_W-1:0]    rs_11,
  output logic signed [OUT_W-1:0]    rs_12,
  output logic signed [OUT_W-1:0]    rs_20,
  output logic signed [OUT_W-1:0]    rs_21,
  output logic signed [OUT_W-1:0]    rs_22,
  output logic signed [POS_W-1:0]    trans_x,
  output logic signed [POS_W-1:0]    trans_y,
  output logic signed [POS_W-1:0]    trans_z
);

  logic accept;

  // Stage valid bits
  logic v1, v2, v3, v4;

  // Stage 1: pair products
  pair_t                     pair1 [N_PAIR];
  logic signed [SCALE_W-1:0] scl1  [N_DIM];
  logic signed [POS_W-1:0]   pos1  [N_DIM];
  pair_t                     pair1_next [N_PAIR];

  // Stage 2: matrix terms
  term_t                     term2 [N_ENT];
  logic signed [SCALE_W-1:0] scl2  [N_DIM];
  logic signed [POS_W-1:0]   pos2  [N_DIM];
  term_t                     term2_next [N_ENT];

  // Stage 3: scaled products
  mul2_t                     mul3  [N_ENT];
  logic signed [POS_W-1:0]   pos3  [N_DIM];
  mul2_t                     mul3_next [N_ENT];

  // Stage 4: clamped outputs
  ent_t                      ent4  [N_ENT];
  logic signed [POS_W-1:0]   pos4  [N_DIM];
  ent_t                      ent4_next [N_ENT];

  assign busy   = rst;
  assign accept = start && !busy;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Pair products, floored to Q.14 by dropping the low fraction bits
  function automatic pair_t qmul(input logic signed [QUAT_W-1:0] a,
                                 input logic signed [QUAT_W-1:0] b);
    logic signed [MUL1_W-1:0] p;
    p = a * b;
    qmul = p[MUL1_W-1:Q_FRAC];
  endfunction

  always_comb begin
    pair1_next[P_XX] = qmul(quat_x, quat_x);
    pair1_next[P_YY] = qmul(quat_y, quat_y);
    pair1_next[P_ZZ] = qmul(quat_z, quat_z);
    pair1_next[P_XY] = qmul(quat_x, quat_y);
    pair1_next[P_XZ] = qmul(quat_x, quat_z);
    pair1_next[P_YZ] = qmul(quat_y, quat_z);
    pair1_next[P_WX] = qmul(quat_w, quat_x);
    pair1_next[P_WY] = qmul(quat_w, quat_y);
    pair1_next[P_WZ] = qmul(quat_w, quat_z);
  end

  always_ff @(posedge clk) begin
    pair1   <= pair1_next;
    scl1[0] <= scale_x;
    scl1[1] <= scale_y;
    scl1[2] <= scale_z;
    pos1[0] <= pos_x;
    pos1[1] <= pos_y;
    pos1[2] <= pos_z;
  end

  // Terms: 2*(a +/- b) off the diagonal, one - 2*(a + b) on it
  function automatic term_t twice_sum(input pair_t a, input pair_t b, input logic sub);
    term_t ea;
    term_t eb;
    term_t s;
    ea = TERM_W'(a);
    eb = TERM_W'(b);
    s  = sub ? (ea - eb) : (ea + eb);
    twice_sum = s <<< 1;
  endfunction

  always_comb begin
    term2_next[0] = ONE_Q14 - twice_sum(pair1[P_YY], pair1[P_ZZ], 1'b0);
    term2_next[1] = twice_sum(pair1[P_XY], pair1[P_WZ], 1'b1);
    term2_next[2] = twice_sum(pair1[P_XZ], pair1[P_WY], 1'b0);
    term2_next[3] = twice_sum(pair1[P_XY], pair1[P_WZ], 1'b0);
    term2_next[4] = ONE_Q14 - twice_sum(pair1[P_XX], pair1[P_ZZ], 1'b0);
    term2_next[5] = twice_sum(pair1[P_YZ], pair1[P_WX], 1'b1);
    term2_next[6] = twice_sum(pair1[P_XZ], pair1[P_WY], 1'b1);
    term2_next[7] = twice_sum(pair1[P_YZ], pair1[P_WX], 1'b0);
    term2_next[8] = ONE_Q14 - twice_sum(pair1[P_XX], pair1[P_YY], 1'b0);
  end

  always_ff @(posedge clk) begin
    term2 <= term2_next;
    scl2  <= scl1;
    pos2  <= pos1;
  end

  // Column j is multiplied by scale j
  always_comb begin
    for (int r = 0; r < N_DIM; r++) begin
      for (int c = 0; c < N_DIM; c++) begin
        mul3_next[r*N_DIM + c] = MUL2_W'(term2[r*N_DIM + c]) * MUL2_W'(scl2[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    mul3 <= mul3_next;
    pos3 <= pos2;
  end

  // Floor shift back to Q.14 and clamp to 24 bits
  always_comb begin
    for (int k = 0; k < N_ENT; k++) begin
      ent4_next[k] = sat_out(mul3[k][MUL2_W-1:S_FRAC]);
    end
  end

  always_ff @(posedge clk) begin
    ent4 <= ent4_next;
    pos4 <= pos3;
  end

  // Result ports
  assign done    = v4;
  assign rs_00   = ent4[0];
  assign rs_01   = ent4[1];
  assign rs_02   = ent4[2];
  assign rs_10   = ent4[3];
  assign rs_11   = ent4[4];
  assign rs_12   = ent4[5];
  assign rs_20   = ent4[6];
  assign rs_21   = ent4[7];
  assign rs_22   = ent4[8];
  assign trans_x = pos4[0];
  assign trans_y = pos4[1];
  assign trans_z = pos4[2];

  // A strobe always traces back to a matching earlier transfer
  a_done_from_accept: assert property (@(posedge clk)
    done |-> $past(accept, LATENCY))
    else $error("done without a matching transfer");

  // Reset empties the pipeline
  a_rst_clears: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done after reset");

  // Translation x and z leave with the item they came in with
  a_pos_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> (trans_x == $past(pos_x, LATENCY)) && (trans_z == $past(pos_z, LATENCY)))
    else $error("position misaligned with its result");

endmodule
